// ===== rtl/set_assoc_lru_writeback_cache_macros.svh =====
// Assertion macros for the set-associative LRU write-back cache.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_MACROS_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
// Shared types and constants of the set-associative LRU write-back cache.
// No dependencies; used by every module of the block but salc_ram.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

  localparam int LINES   = 2048;
  localparam int LINE_AW = 11;
  localparam int WAYS    = 16;
  localparam int WAY_W   = 4;
  localparam int TAG_W   = 30;
  localparam int CNT_N   = 7;
  localparam int PADDR_W = 4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_OB   = 2'd0;
  localparam logic [1:0] REG_IB   = 2'd1;
  localparam logic [1:0] REG_WAYS = 2'd2;

  // Counter slots
  localparam int CNT_READ  = 0;
  localparam int CNT_WRITE = 1;
  localparam int CNT_WB    = 2;
  localparam int CNT_RHIT  = 3;
  localparam int CNT_WHIT  = 4;
  localparam int CNT_RMISS = 5;
  localparam int CNT_WMISS = 6;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way_used;
    logic        write_back;
    logic [31:0] victim_block_address;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [31:0] writeback_count;
    logic [31:0] read_hit_count;
    logic [31:0] write_hit_count;
    logic [31:0] read_miss_count;
    logic [31:0] write_miss_count;
  } res_t;

  // One directory line
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [WAY_W-1:0] rank;
  } ent_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic acc_load;
    logic scan_rd;
    logic k_clr;
    logic upd_rd;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic k_last;
    logic out_free;
    logic cfg_wr;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
    sat_inc = (en && (v != 32'hFFFF_FFFF)) ? v + 32'd1 : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/set_assoc_lru_writeback_cache.sv =====
// Top level of the set-associative LRU write-back cache directory.
// Depends on salc_pkg, salc_ctrl, salc_dp and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_lru_writeback_cache_macros.svh"

// Each access reads the directory RAM once per way in use to find the hit,
// first free way and least recent way, then once per way again to
// rewrite ranks and the filled line; no new access is taken until the
// result is loaded. A finished result sits in an output register, so the
// next access is taken while it waits. After reset and after every write
// to one of the three registers all 2048 directory lines are swept clear
// with in_ready low; statistics counters survive a register write, and a
// write to an unlisted address changes nothing.
module set_assoc_lru_writeback_cache (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire salc_pkg::req_t               in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output salc_pkg::res_t                    out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [salc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  salc_pkg::cmd_t cmd;
  salc_pkg::sts_t sts;
  logic           cfg_flush;
  logic [31:0]    out_victim;

  assign pready = 1'b1;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Write beat to a listed register, and the victim field
  assign cfg_flush = psel && penable && pwrite && pready &&
                     ((paddr[3:2] == salc_pkg::REG_OB) ||
                      (paddr[3:2] == salc_pkg::REG_IB) ||
                      (paddr[3:2] == salc_pkg::REG_WAYS));
  assign out_victim = out_data.victim_block_address;

  // Checks
  `SALC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "busy after accept")
  `SALC_ASSERT_NEXT(a_sweep_after_cfg, cfg_flush, !in_ready, "no sweep after write")
  `SALC_ASSERT_NOW(a_victim, out_valid && !out_data.write_back, out_victim == '0, "bad victim")
  `SALC_ASSERT_NOW(a_hit_no_wb, out_valid && out_data.hit, !out_data.write_back, "wb on hit")

endmodule
`default_nettype wire

// ===== rtl/salc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/salc_ctrl.sv =====
// Sequencer of the cache: clear sweep, set scan, rank rewrite, result hand-off.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire salc_pkg::sts_t sts,
  output salc_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_LAST  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_load = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.k_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.k_clr = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (sts.k_last) state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
    // A register write restarts the clear sweep
    if (sts.cfg_wr) state_nxt = S_CLR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/salc_dp.sv =====
// Datapath of the cache: config registers, directory RAM, LRU search,
// rank rewrite, statistics counters and result register.
// Depends on salc_pkg and salc_ram.
`timescale 1ns / 1ps
`default_nettype none
module salc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire salc_pkg::req_t                in_data,
  output salc_pkg::res_t                     out_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [salc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  input  wire salc_pkg::cmd_t                cmd,
  output salc_pkg::sts_t                     sts
);

  localparam int AW = salc_pkg::LINE_AW;
  localparam int KW = salc_pkg::WAY_W;

  // Configuration registers
  logic [2:0] ob_r;
  logic [3:0] ib_r;
  logic [4:0] ways_r;
  logic       cfg_wr;
  logic       cfg_flush;

  assign cfg_wr = psel && penable && pwrite;

  // Only a write to a listed register flushes the directory
  assign cfg_flush = cfg_wr && ((paddr[3:2] == salc_pkg::REG_OB) ||
                                (paddr[3:2] == salc_pkg::REG_IB) ||
                                (paddr[3:2] == salc_pkg::REG_WAYS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_r   <= 3'd2;
      ib_r   <= 4'd0;
      ways_r <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        salc_pkg::REG_OB:   ob_r   <= pwdata[2:0];
        salc_pkg::REG_IB:   ib_r   <= pwdata[3:0];
        salc_pkg::REG_WAYS: ways_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      salc_pkg::REG_OB:   prdata = {29'd0, ob_r};
      salc_pkg::REG_IB:   prdata = {28'd0, ib_r};
      salc_pkg::REG_WAYS: prdata = {27'd0, ways_r};
      default:            prdata = 32'd0;
    endcase
  end

  // Effective geometry: clamp offset and ways, shrink index to fit
  logic [2:0] ob_e;
  logic [4:0] w_e;
  logic [3:0] ib_c, ib_lim, ib_e;

  always_comb begin
    ob_e = (ob_r < 3'd2) ? 3'd2 : ((ob_r > 3'd5) ? 3'd5 : ob_r);
    w_e  = (ways_r == 5'd0) ? 5'd1 : ((ways_r > 5'd16) ? 5'd16 : ways_r);
    ib_c = (ib_r > 4'd11) ? 4'd11 : ib_r;
    ib_lim = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (({11'd0, w_e} << i) <= 16'd2048) ib_lim = 4'(i);
    end
    ib_e = (ib_c < ib_lim) ? ib_c : ib_lim;
  end

  // Accepted access
  logic                      is_wr_r;
  logic [salc_pkg::TAG_W-1:0] tag_r;
  logic [AW-1:0]             base_r;
  logic [31:0]               aligned;
  logic [AW-1:0]             set_idx;
  logic [15:0]               base_prod;

  assign aligned   = in_data.address & (32'hFFFF_FFFF << ob_e);
  assign set_idx   = AW'(in_data.address >> ob_e) & ~(11'h7FF << ib_e);
  assign base_prod = {5'd0, set_idx} * {11'd0, w_e};

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      is_wr_r <= in_data.req_type;
      tag_r   <= aligned[31:2];
      base_r  <= base_prod[AW-1:0];
    end
  end

  // Way counter and read/write pipeline flags
  logic [KW-1:0] k_r, cap_k_r, wr_k_r;
  logic          cap_v_r, wr_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      cap_v_r <= 1'b0;
      wr_v_r  <= 1'b0;
    end else begin
      if (cmd.acc_load || cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.scan_rd || cmd.upd_rd) begin
        k_r <= k_r + KW'(1);
      end
      cap_v_r <= cmd.scan_rd;
      wr_v_r  <= cmd.upd_rd;
    end
  end

  always_ff @(posedge clk) begin
    cap_k_r <= k_r;
    wr_k_r  <= k_r;
  end

  // Clear sweep
  logic [AW-1:0] clr_idx_r;
  logic [KW-1:0] clr_way_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_flush) begin
      clr_idx_r <= '0;
      clr_way_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      clr_way_r <= ({1'b0, clr_way_r} == w_e - 5'd1) ? '0 : clr_way_r + KW'(1);
    end
  end

  // Directory RAM
  salc_pkg::ent_t rd_ent, wr_ent, upd_ent;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;

  salc_ram #(
    .WIDTH ($bits(salc_pkg::ent_t)),
    .DEPTH (salc_pkg::LINES)
  ) u_dir (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (base_r + {{(AW-KW){1'b0}}, k_r}),
    .rdata (rd_ent)
  );

  // Scan accumulators: hit, first invalid, least recent
  logic          hit_r, inv_r;
  logic [KW-1:0] hit_way_r, hit_rank_r, inv_way_r, inv_rank_r, lru_way_r, lru_rank_r;
  logic          lru_dirty_r;
  logic [salc_pkg::TAG_W-1:0] lru_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_load) begin
      hit_r <= 1'b0;
      inv_r <= 1'b0;
    end else if (cap_v_r) begin
      if (!hit_r && rd_ent.valid && (rd_ent.tag == tag_r)) hit_r <= 1'b1;
      if (!inv_r && !rd_ent.valid) inv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_v_r) begin
      if (!hit_r && rd_ent.valid && (rd_ent.tag == tag_r)) begin
        hit_way_r  <= cap_k_r;
        hit_rank_r <= rd_ent.rank;
      end
      if (!inv_r && !rd_ent.valid) begin
        inv_way_r  <= cap_k_r;
        inv_rank_r <= rd_ent.rank;
      end
      if ((cap_k_r == '0) || (rd_ent.rank > lru_rank_r)) begin
        lru_way_r   <= cap_k_r;
        lru_rank_r  <= rd_ent.rank;
        lru_dirty_r <= rd_ent.dirty;
        lru_tag_r   <= rd_ent.tag;
      end
    end
  end

  // Chosen way and its old rank
  logic [KW-1:0] ch_way, ch_rank;
  logic          wb;

  always_comb begin
    if (hit_r) begin
      ch_way  = hit_way_r;
      ch_rank = hit_rank_r;
    end else if (inv_r) begin
      ch_way  = inv_way_r;
      ch_rank = inv_rank_r;
    end else begin
      ch_way  = lru_way_r;
      ch_rank = lru_rank_r;
    end
    wb = !hit_r && !inv_r && lru_dirty_r;
  end

  // Rewrite one line of the set: promote chosen way, age the newer ones
  always_comb begin
    upd_ent = rd_ent;
    if (wr_k_r == ch_way) begin
      upd_ent.tag   = hit_r ? rd_ent.tag : tag_r;
      upd_ent.valid = 1'b1;
      upd_ent.dirty = hit_r ? (rd_ent.dirty | is_wr_r) : is_wr_r;
      upd_ent.rank  = '0;
    end else if (rd_ent.rank < ch_rank) begin
      upd_ent.rank = rd_ent.rank + KW'(1);
    end
  end

  always_comb begin
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      wr_ent    = '{tag: '0, valid: 1'b0, dirty: 1'b0, rank: clr_way_r};
    end else begin
      ram_we    = wr_v_r;
      ram_waddr = base_r + {{(AW-KW){1'b0}}, wr_k_r};
      wr_ent    = upd_ent;
    end
  end

  // Statistics counters
  logic [31:0] cnt_r   [salc_pkg::CNT_N];
  logic [31:0] cnt_nxt [salc_pkg::CNT_N];

  always_comb begin
    cnt_nxt[salc_pkg::CNT_READ]  = salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_READ], !is_wr_r);
    cnt_nxt[salc_pkg::CNT_WRITE] = salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_WRITE], is_wr_r);
    cnt_nxt[salc_pkg::CNT_WB]    = salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_WB], wb);
    cnt_nxt[salc_pkg::CNT_RHIT]  =
      salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_RHIT], !is_wr_r && hit_r);
    cnt_nxt[salc_pkg::CNT_WHIT]  =
      salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_WHIT], is_wr_r && hit_r);
    cnt_nxt[salc_pkg::CNT_RMISS] =
      salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_RMISS], !is_wr_r && !hit_r);
    cnt_nxt[salc_pkg::CNT_WMISS] =
      salc_pkg::sat_inc(cnt_r[salc_pkg::CNT_WMISS], is_wr_r && !hit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < salc_pkg::CNT_N; i++) cnt_r[i] <= '0;
    end else if (cmd.out_load) begin
      for (int i = 0; i < salc_pkg::CNT_N; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  // Result register
  logic            out_valid_r;
  salc_pkg::res_t  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.hit                  <= hit_r;
      out_data_r.way_used             <= ch_way;
      out_data_r.write_back           <= wb;
      out_data_r.victim_block_address <= wb ? {lru_tag_r, 2'b00} : 32'd0;
      out_data_r.read_count           <= cnt_nxt[salc_pkg::CNT_READ];
      out_data_r.write_count          <= cnt_nxt[salc_pkg::CNT_WRITE];
      out_data_r.writeback_count      <= cnt_nxt[salc_pkg::CNT_WB];
      out_data_r.read_hit_count       <= cnt_nxt[salc_pkg::CNT_RHIT];
      out_data_r.write_hit_count      <= cnt_nxt[salc_pkg::CNT_WHIT];
      out_data_r.read_miss_count      <= cnt_nxt[salc_pkg::CNT_RMISS];
      out_data_r.write_miss_count     <= cnt_nxt[salc_pkg::CNT_WMISS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller
  assign sts.clr_last = &clr_idx_r;
  assign sts.k_last   = ({1'b0, k_r} == w_e - 5'd1);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.cfg_wr   = cfg_flush;

endmodule
`default_nettype wire

// ===== tb/set_assoc_lru_writeback_cache_checker.sv =====
// Checker for the set-associative LRU write-back cache: watches the request,
// result and register ports, predicts each result and compares it.
// Depends on salc_pkg for the beat types and counter slots.
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  salc_pkg::req_t               in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  salc_pkg::res_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [salc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           errors,
  output int                           pending
);

  // Shadow directory and statistics
  logic [31:0] line_addr[salc_pkg::LINES];
  bit          line_vld[salc_pkg::LINES];
  bit          line_drt[salc_pkg::LINES];
  int          line_rank[salc_pkg::LINES];
  logic [31:0] stats[salc_pkg::CNT_N];

  // Register values as written, and the geometry they select
  int          ob_reg, ib_reg, ways_reg;
  int          ob_eff, ib_eff, ways_eff;

  salc_pkg::res_t expected_results[$];

  assign pending = expected_results.size();

  initial errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Clamp the registers to a usable geometry, then clear every line
  task automatic flush_lines();
    ob_eff = ob_reg & 7;
    ib_eff = ib_reg & 15;
    ways_eff = ways_reg & 31;
    if (ob_eff < 2) ob_eff = 2;
    if (ob_eff > 5) ob_eff = 5;
    if (ways_eff == 0) ways_eff = 1;
    if (ways_eff > salc_pkg::WAYS) ways_eff = salc_pkg::WAYS;
    if (ib_eff > 11) ib_eff = 11;
    while (ib_eff > 0 && (ways_eff << ib_eff) > salc_pkg::LINES) ib_eff--;
    for (int i = 0; i < salc_pkg::LINES; i++) begin
      line_addr[i] = '0;
      line_vld[i] = 0;
      line_drt[i] = 0;
      line_rank[i] = i % ways_eff;
    end
  endtask

  function automatic logic [31:0] bumped(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Age every way more recent than the touched one, then make it rank zero
  task automatic promote(input int base, input int way);
    int r;
    r = line_rank[base + way];
    for (int k = 0; k < ways_eff; k++)
      if (line_rank[base + k] < r) line_rank[base + k]++;
    line_rank[base + way] = 0;
  endtask

  task automatic predict_access(input salc_pkg::req_t r);
    logic [31:0]    set_idx, aligned;
    int             base, way, best;
    bit             found;
    salc_pkg::res_t e;
    set_idx = (r.address >> ob_eff) & ((32'd1 << ib_eff) - 1);
    aligned = r.address & ~((32'd1 << ob_eff) - 1);
    base = set_idx * ways_eff;
    e = '0;
    way = 0;
    found = 0;
    for (int k = 0; k < ways_eff && !found; k++)
      if (line_vld[base + k] && line_addr[base + k] == aligned) begin
        found = 1;
        way = k;
      end
    if (found) begin
      e.hit = 1'b1;
      promote(base, way);
      if (r.req_type) begin
        line_drt[base + way] = 1;
        stats[salc_pkg::CNT_WRITE] = bumped(stats[salc_pkg::CNT_WRITE]);
        stats[salc_pkg::CNT_WHIT] = bumped(stats[salc_pkg::CNT_WHIT]);
      end else begin
        stats[salc_pkg::CNT_READ] = bumped(stats[salc_pkg::CNT_READ]);
        stats[salc_pkg::CNT_RHIT] = bumped(stats[salc_pkg::CNT_RHIT]);
      end
    end else begin
      // Pick the first free way, else the least recent, lowest way on a tie
      for (int k = 0; k < ways_eff && !found; k++)
        if (!line_vld[base + k]) begin
          found = 1;
          way = k;
        end
      if (!found) begin
        best = line_rank[base];
        for (int k = 1; k < ways_eff; k++)
          if (line_rank[base + k] > best) begin
            best = line_rank[base + k];
            way = k;
          end
      end
      if (line_vld[base + way] && line_drt[base + way]) begin
        e.write_back = 1'b1;
        e.victim_block_address = line_addr[base + way];
        stats[salc_pkg::CNT_WB] = bumped(stats[salc_pkg::CNT_WB]);
      end
      line_addr[base + way] = aligned;
      line_vld[base + way] = 1;
      line_drt[base + way] = r.req_type;
      promote(base, way);
      if (r.req_type) begin
        stats[salc_pkg::CNT_WRITE] = bumped(stats[salc_pkg::CNT_WRITE]);
        stats[salc_pkg::CNT_WMISS] = bumped(stats[salc_pkg::CNT_WMISS]);
      end else begin
        stats[salc_pkg::CNT_READ] = bumped(stats[salc_pkg::CNT_READ]);
        stats[salc_pkg::CNT_RMISS] = bumped(stats[salc_pkg::CNT_RMISS]);
      end
    end
    e.way_used = way[3:0];
    e.read_count = stats[salc_pkg::CNT_READ];
    e.write_count = stats[salc_pkg::CNT_WRITE];
    e.writeback_count = stats[salc_pkg::CNT_WB];
    e.read_hit_count = stats[salc_pkg::CNT_RHIT];
    e.write_hit_count = stats[salc_pkg::CNT_WHIT];
    e.read_miss_count = stats[salc_pkg::CNT_RMISS];
    e.write_miss_count = stats[salc_pkg::CNT_WMISS];
    expected_results.push_back(e);
  endtask

  task automatic compare_result(input salc_pkg::res_t got);
    salc_pkg::res_t want;
    if (expected_results.size() == 0) begin
      report("unexpected result beat", 32'd1, 32'd0);
      return;
    end
    want = expected_results.pop_front();
    if (got.hit !== want.hit) report("hit", got.hit, want.hit);
    if (got.way_used !== want.way_used) report("way_used", got.way_used, want.way_used);
    if (got.write_back !== want.write_back)
      report("write_back", got.write_back, want.write_back);
    if (got.victim_block_address !== want.victim_block_address)
      report("victim_block_address", got.victim_block_address, want.victim_block_address);
    if (got.read_count !== want.read_count)
      report("read_count", got.read_count, want.read_count);
    if (got.write_count !== want.write_count)
      report("write_count", got.write_count, want.write_count);
    if (got.writeback_count !== want.writeback_count)
      report("writeback_count", got.writeback_count, want.writeback_count);
    if (got.read_hit_count !== want.read_hit_count)
      report("read_hit_count", got.read_hit_count, want.read_hit_count);
    if (got.write_hit_count !== want.write_hit_count)
      report("write_hit_count", got.write_hit_count, want.write_hit_count);
    if (got.read_miss_count !== want.read_miss_count)
      report("read_miss_count", got.read_miss_count, want.read_miss_count);
    if (got.write_miss_count !== want.write_miss_count)
      report("write_miss_count", got.write_miss_count, want.write_miss_count);
  endtask

  // Track reset, register writes, accepted requests and accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      ob_reg = 2;
      ib_reg = 0;
      ways_reg = 1;
      for (int i = 0; i < salc_pkg::CNT_N; i++) stats[i] = '0;
      flush_lines();
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          salc_pkg::REG_OB: begin
            ob_reg = pwdata & 7;
            flush_lines();
          end
          salc_pkg::REG_IB: begin
            ib_reg = pwdata & 15;
            flush_lines();
          end
          salc_pkg::REG_WAYS: begin
            ways_reg = pwdata & 31;
            flush_lines();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_access(in_data);
      if (out_valid && out_ready) compare_result(out_data);
    end
  end

endmodule

// ===== tb/set_assoc_lru_writeback_cache_tb.sv =====
// Top of the cache testbench: clock, reset, register writes and request
// stimulus with idle phases; depends on salc_pkg, the block and its checker.
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_tb;

  // Register index that maps to nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  salc_pkg::req_t                in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  salc_pkg::res_t                out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [salc_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  int                            errors, pending;

  // Idle percentages of the current phase
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic [31:0]         hot_blocks[24];

  set_assoc_lru_writeback_cache uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  set_assoc_lru_writeback_cache_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stall the result channel at the phase's rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Setup phase, access phase, then a return to idle before the next write
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the beat until accepted, then maybe leave a gap
  task automatic send_access(input logic wr, input logic [31:0] addr);
    in_data <= '{req_type: wr, address: addr};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every result, then cover the longest access
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_geometry(input int ob, input int ib, input int ways);
    reg_write(salc_pkg::REG_OB, ob);
    reg_write(salc_pkg::REG_IB, ib);
    reg_write(salc_pkg::REG_WAYS, ways);
  endtask

  task automatic random_access();
    logic [31:0] a;
    if ($urandom_range(0, 99) < 80) a = hot_blocks[$urandom_range(0, 23)] | $urandom_range(0, 3);
    else a = $urandom;
    send_access(1'($urandom_range(0, 1)), a);
  endtask

  int geo[8][3] = '{'{5, 11, 1}, '{2, 7, 16}, '{3, 4, 4}, '{4, 0, 16},
                    '{0, 15, 0}, '{7, 9, 31}, '{2, 3, 2}, '{3, 10, 3}};

  initial begin
    logic [15:0] low_a, low_b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default geometry: one set, one way; hits, dirty evictions, extremes
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_0003);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'hFFFF_FFFC);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0001);
    send_access(1'b0, 32'hAAAA_AAAA);
    send_access(1'b1, 32'h5555_5555);
    send_access(1'b0, 32'h5555_5554);
    drain();

    // Unmapped register, then a flush with dirty lines present
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h1234_5678);
    drain();
    set_geometry(2, 0, 2);
    send_access(1'b0, 32'h1234_5678);
    send_access(1'b1, 32'h0000_0010);
    send_access(1'b1, 32'h0000_0020);
    send_access(1'b0, 32'h1234_5678);
    send_access(1'b0, 32'h0000_0010);
    send_access(1'b1, 32'h8000_0000);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_geometry(geo[p][0], geo[p][1], geo[p][2]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // Two shared low halves so many blocks collide in the same sets
      low_a = 16'($urandom);
      low_b = 16'($urandom);
      for (int i = 0; i < 24; i++)
        hot_blocks[i] = {16'($urandom), (i % 2) ? low_b : low_a} & 32'hFFFF_FFFC;
      for (int i = 0; i < 66; i++) begin
        if (p == 2 && i == 33) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
        random_access();
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
